// ===== rtl/ncc_pkg.sv =====
// Shared types and constants for the nearest-centroid classifier.
`default_nettype none

package ncc_pkg;

    localparam int DATA_W  = 16;
    localparam int IDX_W   = 4;
    localparam int CLASS_W = 4;
    localparam int REG_W   = 5;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;
    localparam int SQ_W    = 32;

    localparam logic [REG_W-1:0] REG_RESET_VALUE = 5'd16;

    // Register indexes, taken from paddr[2].
    localparam logic [0:0] REG_NUM_CLUSTERS  = 1'b0;
    localparam logic [0:0] REG_VECTOR_LENGTH = 1'b1;

    typedef struct packed {
        logic [REG_W-1:0] num_clusters;
        logic [REG_W-1:0] vector_length;
        logic             clear;
    } ncc_cfg_t;

endpackage

`default_nettype wire

// ===== rtl/ncc_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module ncc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ncc_cfg.sv =====
// APB configuration registers: cluster count and vector length.
`default_nettype none

module ncc_cfg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ncc_pkg::APB_AW-1:0]    paddr,
    input  wire logic [ncc_pkg::APB_DW-1:0]    pwdata,
    output logic      [ncc_pkg::APB_DW-1:0]    prdata,
    output logic                               pready,
    output ncc_pkg::ncc_cfg_t                  cfg
);

    import ncc_pkg::*;

    logic [REG_W-1:0] num_clusters_reg;
    logic [REG_W-1:0] num_clusters_next;
    logic [REG_W-1:0] vector_length_reg;
    logic [REG_W-1:0] vector_length_next;
    logic             wr_en;
    logic [0:0]       reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    always_comb
    begin
        num_clusters_next  = num_clusters_reg;
        vector_length_next = vector_length_reg;
        if (wr_en)
        begin
            case (reg_sel)
                REG_NUM_CLUSTERS:  num_clusters_next  = pwdata[REG_W-1:0];
                REG_VECTOR_LENGTH: vector_length_next = pwdata[REG_W-1:0];
                default:           num_clusters_next  = num_clusters_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_clusters_reg  <= REG_RESET_VALUE;
            vector_length_reg <= REG_RESET_VALUE;
        end
        else
        begin
            num_clusters_reg  <= num_clusters_next;
            vector_length_reg <= vector_length_next;
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_NUM_CLUSTERS:  prdata = APB_DW'(num_clusters_reg);
            REG_VECTOR_LENGTH: prdata = APB_DW'(vector_length_reg);
            default:           prdata = '0;
        endcase
    end

    // Any register write abandons a query in progress.
    assign cfg.num_clusters  = num_clusters_reg;
    assign cfg.vector_length = vector_length_reg;
    assign cfg.clear         = wr_en;

endmodule

`default_nettype wire

// ===== rtl/ncc_engine.sv =====
// Distance engine: centroid and distance-sum memories with a three-stage read-modify-write pass.
`default_nettype none

module ncc_engine #(
    parameter int MAX_CLUSTERS = 16,
    parameter int MAX_DIM      = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire ncc_pkg::ncc_cfg_t               cfg,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic                            mode,
    input  wire logic [ncc_pkg::IDX_W-1:0]       centroid_index,
    input  wire logic [ncc_pkg::IDX_W-1:0]       element_index,
    input  wire logic signed [ncc_pkg::DATA_W-1:0] sample_value,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic      [ncc_pkg::CLASS_W-1:0]     class_index
);

    import ncc_pkg::*;

    localparam int CW    = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int DW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int NCW   = $clog2(MAX_CLUSTERS + 1);
    localparam int VLW   = $clog2(MAX_DIM + 1);
    localparam int AW    = CW + DW;
    localparam int CDEPTH = 1 << AW;
    localparam int SDEPTH = 1 << CW;
    localparam int SUM_W = SQ_W + ((MAX_DIM > 1) ? $clog2(MAX_DIM) : 0);

    // Control state.
    logic          a_busy_reg, a_busy_next;
    logic [CW-1:0] a_c_reg, a_c_next;
    logic          b_v_reg, b_last_c_reg;
    logic [CW-1:0] b_c_reg;
    logic          c_v_reg, c_last_c_reg;
    logic [CW-1:0] c_c_reg;
    logic [DW-1:0] elem_cnt_reg, elem_cnt_next;
    logic          out_valid_reg, out_valid_next;

    // Payload of the item in flight.
    logic signed [DATA_W-1:0] x_reg;
    logic [DW-1:0]            pos_reg;
    logic                     q_first_reg;
    logic                     q_last_reg;
    logic [CW-1:0]            nc_last_reg;
    logic [SQ_W-1:0]          sq_reg;
    logic [SUM_W-1:0]         best_d_reg;
    logic [CW-1:0]            best_c_reg;
    logic [CLASS_W-1:0]       class_reg, class_next;

    logic [NCW-1:0]     nc_clamped;
    logic [VLW-1:0]     vl_clamped;
    logic [CW-1:0]      nc_last;
    logic [VLW-1:0]     pos_plus_one;
    logic               elem_is_last;
    logic               pipe_idle;
    logic               accept;
    logic               load_we;
    logic [AW-1:0]      load_addr;
    logic [DATA_W-1:0]  cent_rdata;
    logic [SUM_W-1:0]   sum_rdata;
    logic [SUM_W-1:0]   sum_old;
    logic [SUM_W-1:0]   sum_new;
    logic               better;
    logic signed [DATA_W:0] diff;
    logic [DATA_W-1:0]  abs_diff;

    always_comb
    begin
        if (cfg.num_clusters == '0)
        begin
            nc_clamped = NCW'(1);
        end
        else if (32'(cfg.num_clusters) > MAX_CLUSTERS)
        begin
            nc_clamped = NCW'(MAX_CLUSTERS);
        end
        else
        begin
            nc_clamped = NCW'(cfg.num_clusters);
        end

        if (cfg.vector_length == '0)
        begin
            vl_clamped = VLW'(1);
        end
        else if (32'(cfg.vector_length) > MAX_DIM)
        begin
            vl_clamped = VLW'(MAX_DIM);
        end
        else
        begin
            vl_clamped = VLW'(cfg.vector_length);
        end
    end

    assign nc_last      = CW'(nc_clamped - NCW'(1));
    assign pos_plus_one = VLW'(elem_cnt_reg) + VLW'(1);
    assign elem_is_last = (pos_plus_one >= vl_clamped);

    assign pipe_idle = !a_busy_reg && !b_v_reg && !c_v_reg;
    assign in_ready  = pipe_idle && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;

    // Centroid writes that fall outside the table are dropped.
    assign load_we   = accept && !mode
                       && (32'(centroid_index) < MAX_CLUSTERS)
                       && (32'(element_index) < MAX_DIM);
    assign load_addr = {CW'(centroid_index), DW'(element_index)};

    ncc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CDEPTH)
    ) u_centroid_ram (
        .clk   (clk),
        .we    (load_we),
        .waddr (load_addr),
        .wdata (sample_value),
        .re    (a_busy_reg),
        .raddr ({a_c_reg, pos_reg}),
        .rdata (cent_rdata)
    );

    // The first element of a query ignores what the sum memory holds, so it
    // never needs clearing.
    ncc_ram #(
        .WIDTH (SUM_W),
        .DEPTH (SDEPTH)
    ) u_sum_ram (
        .clk   (clk),
        .we    (c_v_reg),
        .waddr (c_c_reg),
        .wdata (sum_new),
        .re    (b_v_reg),
        .raddr (b_c_reg),
        .rdata (sum_rdata)
    );

    // Stage B: difference and square.
    always_comb
    begin
        diff = {x_reg[DATA_W-1], x_reg} - {cent_rdata[DATA_W-1], cent_rdata};
        if (diff[DATA_W])
        begin
            abs_diff = DATA_W'(-diff);
        end
        else
        begin
            abs_diff = diff[DATA_W-1:0];
        end
    end

    // Stage C: accumulate and track the running minimum.
    assign sum_old = q_first_reg ? '0 : sum_rdata;
    assign sum_new = sum_old + SUM_W'(sq_reg);
    assign better  = (c_c_reg == '0) || (sum_new < best_d_reg);

    always_comb
    begin
        a_busy_next    = a_busy_reg;
        a_c_next       = a_c_reg;
        elem_cnt_next  = elem_cnt_reg;
        out_valid_next = out_valid_reg;
        class_next     = class_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (a_busy_reg)
        begin
            if (a_c_reg == nc_last_reg)
            begin
                a_busy_next = 1'b0;
            end
            else
            begin
                a_c_next = a_c_reg + CW'(1);
            end
        end

        if (accept && mode)
        begin
            a_busy_next = 1'b1;
            a_c_next    = '0;
            if (elem_is_last)
            begin
                elem_cnt_next = '0;
            end
            else
            begin
                elem_cnt_next = DW'(pos_plus_one);
            end
        end

        if (c_v_reg && c_last_c_reg && q_last_reg)
        begin
            out_valid_next = 1'b1;
            class_next     = better ? CLASS_W'(c_c_reg) : CLASS_W'(best_c_reg);
        end

        if (cfg.clear)
        begin
            elem_cnt_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_busy_reg    <= 1'b0;
            a_c_reg       <= '0;
            b_v_reg       <= 1'b0;
            b_c_reg       <= '0;
            b_last_c_reg  <= 1'b0;
            c_v_reg       <= 1'b0;
            c_c_reg       <= '0;
            c_last_c_reg  <= 1'b0;
            elem_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            a_busy_reg    <= a_busy_next;
            a_c_reg       <= a_c_next;
            b_v_reg       <= a_busy_reg;
            b_c_reg       <= a_c_reg;
            b_last_c_reg  <= (a_c_reg == nc_last_reg);
            c_v_reg       <= b_v_reg;
            c_c_reg       <= b_c_reg;
            c_last_c_reg  <= b_last_c_reg;
            elem_cnt_reg  <= elem_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && mode)
        begin
            x_reg       <= sample_value;
            pos_reg     <= elem_cnt_reg;
            q_first_reg <= (elem_cnt_reg == '0);
            q_last_reg  <= elem_is_last;
            nc_last_reg <= nc_last;
        end
        sq_reg    <= SQ_W'(abs_diff * abs_diff);
        class_reg <= class_next;
        if (c_v_reg && q_last_reg && better)
        begin
            best_d_reg <= sum_new;
            best_c_reg <= c_c_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign class_index = class_reg;

endmodule

`default_nettype wire

// ===== rtl/nearest_centroid_classifier.sv =====
// Top level of the nearest-centroid classifier.
// A load item writes the centroid memory directly and does not occupy the engine. A query
// element occupies the engine while it reads one centroid from the centroid memory per cycle,
// and no new item is taken until it has left the pipeline and any waiting result is taken.
// Reset clears the control state and sets both registers to 16; the memories are not cleared
// and need no clearing pass.
`default_nettype none

module nearest_centroid_classifier #(
    parameter int MAX_CLUSTERS = 16,
    parameter int MAX_DIM      = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic                                mode,
    input  wire logic [ncc_pkg::IDX_W-1:0]           centroid_index,
    input  wire logic [ncc_pkg::IDX_W-1:0]           element_index,
    input  wire logic signed [ncc_pkg::DATA_W-1:0]   sample_value,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic      [ncc_pkg::CLASS_W-1:0]         class_index,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [ncc_pkg::APB_AW-1:0]          paddr,
    input  wire logic [ncc_pkg::APB_DW-1:0]          pwdata,
    output logic      [ncc_pkg::APB_DW-1:0]          prdata,
    output logic                                     pready
);

    import ncc_pkg::*;

    ncc_cfg_t cfg;

    ncc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ncc_engine #(
        .MAX_CLUSTERS (MAX_CLUSTERS),
        .MAX_DIM      (MAX_DIM)
    ) u_engine (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .centroid_index (centroid_index),
        .element_index  (element_index),
        .sample_value   (sample_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .class_index    (class_index)
    );

endmodule

`default_nettype wire

// ===== rtl/ncc_checker.sv =====
// Port-level checker for the nearest-centroid classifier, with its bind.
`default_nettype none

module ncc_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_ready,
    input wire logic                          mode,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic [ncc_pkg::CLASS_W-1:0]   class_index
);

    import ncc_pkg::*;

    // A waiting result holds until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(class_index))
        else $error("result changed or dropped while stalled");

    // No item is taken while a result is stuck at the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("item accepted while result is stalled");

    // A result never appears in the cycle right after an item is accepted.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result appeared too early");

    // Accepting a query element drops in_ready while the element is in flight.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && mode |=> !in_ready)
        else $error("ready while a query element is in flight");

endmodule

bind nearest_centroid_classifier ncc_checker u_ncc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .mode        (mode),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .class_index (class_index)
);

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the nearest-centroid classifier.
`timescale 1ns / 1ps

module tb;

    import ncc_pkg::*;

    localparam int MAX_CLUSTERS  = 16;
    localparam int MAX_DIM       = 16;
    localparam int SETTLE_CYCLES = 2 * (MAX_CLUSTERS + 2);
    localparam int HOLD_CYCLES   = 400;
    localparam int NUM_PHASES    = 12;
    localparam int PHASE_ITEMS   = 100;
    localparam int MAX_REPORTS   = 10;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef enum logic {ROW_ITEM, ROW_REG} row_kind_e;

    typedef struct packed {
        row_kind_e               kind;
        logic [0:0]              sel;
        logic                    md;
        logic [IDX_W-1:0]        ci;
        logic [IDX_W-1:0]        ei;
        logic signed [DATA_W-1:0] val;
        logic                    has_exp;
        logic [CLASS_W-1:0]      exp_cls;
    } dir_row_t;

    localparam int NUM_ROWS = 21;

    // Fields: kind, register, mode, centroid, element, value, known result, class.
    localparam dir_row_t DIRECTED [0:NUM_ROWS-1] = '{
        '{ROW_REG,  REG_NUM_CLUSTERS,  MODE_LOAD,  4'd0,  4'd0, 16'sd2,      1'b0, 4'd0},
        '{ROW_REG,  REG_VECTOR_LENGTH, MODE_LOAD,  4'd0,  4'd0, 16'sd1,      1'b0, 4'd0},
        '{ROW_ITEM, REG_NUM_CLUSTERS,  MODE_LOAD,  4'd0,  4'd0, 16'sh8000,   1'b0, 4'd0},
        '{ROW_ITEM, REG_NUM_CLUSTERS,  MODE_LOAD,  4'd1,  4'd0, 16'sh7FFF,   1'b0, 4'd0},
        '{ROW_ITEM, REG_NUM_CLUSTERS,  MODE_QUERY, 4'd0,  4'd0, 16'sh7FFF,   1'b1, 4'd1},
        '{ROW_ITEM, REG_NUM_CLUSTERS,  MODE_QUERY, 4'd15, 4'd15, 16'sh8000,  1'b1, 4'd0},
        '{ROW_ITEM, REG_NUM_CLUSTERS,  MODE_QUERY, 4'd0,  4'd0, 16'sd0,      1'b1, 4'd1},
        '{ROW_ITEM, REG_NUM_CLUSTERS,  MODE_QUERY, 4'd0,  4'd0, 16'shFFFF,   1'b1, 4'd0},
        // Both centroids now equal, so the lower index must win the tie.
        '{ROW_ITEM, REG_NUM_CLUSTERS,  MODE_LOAD,  4'd1,  4'd0, 16'sh8000,   1'b0, 4'd0},
        '{ROW_ITEM, REG_NUM_CLUSTERS,  MODE_QUERY, 4'd0,  4'd0, 16'sd5,      1'b1, 4'd0},
        '{ROW_REG,  REG_NUM_CLUSTERS,  MODE_LOAD,  4'd0,  4'd0, 16'sd0,      1'b0, 4'd0},
        '{ROW_ITEM, REG_NUM_CLUSTERS,  MODE_QUERY, 4'd0,  4'd0, 16'sh7FFF,   1'b1, 4'd0},
        '{ROW_REG,  REG_NUM_CLUSTERS,  MODE_LOAD,  4'd0,  4'd0, 16'sd31,     1'b0, 4'd0},
        '{ROW_ITEM, REG_NUM_CLUSTERS,  MODE_LOAD,  4'd15, 4'd0, 16'sd12345,  1'b0, 4'd0},
        '{ROW_ITEM, REG_NUM_CLUSTERS,  MODE_QUERY, 4'd0,  4'd0, 16'sd12345,  1'b0, 4'd0},
        '{ROW_REG,  REG_VECTOR_LENGTH, MODE_LOAD,  4'd0,  4'd0, 16'sd2,      1'b0, 4'd0},
        '{ROW_ITEM, REG_NUM_CLUSTERS,  MODE_QUERY, 4'd0,  4'd0, 16'sd100,    1'b0, 4'd0},
        // A load in the middle of a query is used by its later element.
        '{ROW_ITEM, REG_NUM_CLUSTERS,  MODE_LOAD,  4'd2,  4'd1, 16'sd100,    1'b0, 4'd0},
        '{ROW_ITEM, REG_NUM_CLUSTERS,  MODE_QUERY, 4'd0,  4'd0, -16'sd7,     1'b0, 4'd0},
        '{ROW_ITEM, REG_NUM_CLUSTERS,  MODE_QUERY, 4'd0,  4'd0, 16'sd9,      1'b0, 4'd0},
        // The register write abandons the query left open above.
        '{ROW_REG,  REG_VECTOR_LENGTH, MODE_LOAD,  4'd0,  4'd0, 16'sd31,     1'b0, 4'd0}
    };

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic                      mode;
    logic [IDX_W-1:0]          centroid_index;
    logic [IDX_W-1:0]          element_index;
    logic signed [DATA_W-1:0]  sample_value;
    logic                      out_valid;
    logic                      out_ready;
    logic [CLASS_W-1:0]        class_index;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [APB_AW-1:0]         paddr;
    logic [APB_DW-1:0]         pwdata;
    logic [APB_DW-1:0]         prdata;
    logic                      pready;

    // Known result that travels with the item on the input port.
    logic                      known_en;
    logic [CLASS_W-1:0]        known_cls;

    bit                        sender_idle_en;
    bit                        sink_idle_en;
    bit                        hold_req;

    logic signed [DATA_W-1:0]  cent_mem [MAX_CLUSTERS][MAX_DIM];
    logic [37:0]               dist_acc [MAX_CLUSTERS];
    int unsigned               elem_pos;
    logic [REG_W-1:0]          nc_reg;
    logic [REG_W-1:0]          vl_reg;

    logic [CLASS_W-1:0]        pending_class [$];
    int                        mismatch_count;

    nearest_centroid_classifier #(
        .MAX_CLUSTERS (MAX_CLUSTERS),
        .MAX_DIM      (MAX_DIM)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .centroid_index (centroid_index),
        .element_index  (element_index),
        .sample_value   (sample_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .class_index    (class_index),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic int clamp_count(logic [REG_W-1:0] r, int maxv);
        if (r == 0)
            return 1;
        if (int'(r) > maxv)
            return maxv;
        return int'(r);
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value(bit narrow);
        if (narrow)
            return DATA_W'(int'($urandom_range(0, 6)) - 3);
        case ($urandom_range(0, 7))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            default: return DATA_W'($urandom);
        endcase
    endfunction

    task automatic clear_distances();
        elem_pos = 0;
        for (int c = 0; c < MAX_CLUSTERS; c++)
            dist_acc[c] = '0;
    endtask

    // Updates the centroid table or the running distances for one item and
    // reports the nearest centroid when the item closes a query vector.
    task automatic classify_item(input logic md, input logic [IDX_W-1:0] ci,
                                 input logic [IDX_W-1:0] ei,
                                 input logic signed [DATA_W-1:0] v,
                                 output bit produced, output logic [CLASS_W-1:0] cls);
        int           nc;
        int           vl;
        int           pos;
        int           best;
        longint       diff;
        logic [37:0]  best_sum;
        produced = 1'b0;
        cls = '0;
        if (md == MODE_LOAD)
        begin
            cent_mem[ci][ei] = v;
        end
        else
        begin
            nc = clamp_count(nc_reg, MAX_CLUSTERS);
            vl = clamp_count(vl_reg, MAX_DIM);
            pos = elem_pos % MAX_DIM;
            for (int c = 0; c < nc; c++)
            begin
                diff = longint'(v) - longint'(cent_mem[c][pos]);
                dist_acc[c] = dist_acc[c] + 38'(diff * diff);
            end
            elem_pos = pos + 1;
            if (elem_pos >= vl)
            begin
                best = 0;
                best_sum = dist_acc[0];
                for (int c = 1; c < nc; c++)
                begin
                    if (dist_acc[c] < best_sum)
                    begin
                        best_sum = dist_acc[c];
                        best = c;
                    end
                end
                produced = 1'b1;
                cls = CLASS_W'(best);
                clear_distances();
            end
        end
    endtask

    always @(posedge clk)
    begin
        bit                 produced;
        logic [CLASS_W-1:0] cls;
        logic [CLASS_W-1:0] queued_cls;
        if (rst_n && in_valid && in_ready)
        begin
            classify_item(mode, centroid_index, element_index, sample_value, produced, cls);
            if (produced)
            begin
                queued_cls = known_en ? known_cls : cls;
                pending_class = {pending_class, queued_cls};
            end
        end
    end

    always @(posedge clk)
    begin
        logic [CLASS_W-1:0] want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_class.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result: class_index=%0d", class_index);
            end
            else
            begin
                want = pending_class.pop_front();
                if (class_index !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("class_index mismatch: expected %0d, got %0d",
                                 want, class_index);
                end
            end
        end
    end

    // Result side: random stall bursts, plus one long hold-off on request.
    initial
    begin
        int n;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
                out_ready <= 1'b1;
            end
            else if (sink_idle_en && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 16);
                out_ready <= 1'b0;
                repeat (n) @(negedge clk);
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic send_item(input logic md, input logic [IDX_W-1:0] ci,
                             input logic [IDX_W-1:0] ei, input logic signed [DATA_W-1:0] v,
                             input logic has_exp, input logic [CLASS_W-1:0] exp_cls);
        int gap;
        if (sender_idle_en && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 16);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid       <= 1'b1;
        mode           <= md;
        centroid_index <= ci;
        element_index  <= ei;
        sample_value   <= v;
        known_en       <= has_exp;
        known_cls      <= exp_cls;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Stops offering items, waits for every expected result and lets any
    // element still in the engine finish.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_class.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [0:0] sel, input logic [APB_DW-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (sel == REG_NUM_CLUSTERS)
            nc_reg = value[REG_W-1:0];
        else
            vl_reg = value[REG_W-1:0];
        clear_distances();
    endtask

    initial
    begin
        logic [APB_DW-1:0] nc_val;
        logic [APB_DW-1:0] vl_val;
        bit                narrow;
        in_valid       = 1'b0;
        mode           = MODE_LOAD;
        centroid_index = '0;
        element_index  = '0;
        sample_value   = '0;
        known_en       = 1'b0;
        known_cls      = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        sender_idle_en = 1'b1;
        sink_idle_en   = 1'b1;
        hold_req       = 1'b0;
        mismatch_count = 0;
        nc_reg         = REG_RESET_VALUE;
        vl_reg         = REG_RESET_VALUE;
        clear_distances();
        rst_n = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // Fill the whole centroid table so that no query reads an unwritten entry.
        for (int c = 0; c < MAX_CLUSTERS; c++)
            for (int e = 0; e < MAX_DIM; e++)
                send_item(MODE_LOAD, IDX_W'(c), IDX_W'(e), pick_value(1'b0), 1'b0, '0);

        for (int r = 0; r < NUM_ROWS; r++)
        begin
            if (DIRECTED[r].kind == ROW_REG)
            begin
                settle();
                write_reg(DIRECTED[r].sel, APB_DW'(unsigned'(DIRECTED[r].val)));
            end
            else
            begin
                send_item(DIRECTED[r].md, DIRECTED[r].ci, DIRECTED[r].ei, DIRECTED[r].val,
                          DIRECTED[r].has_exp, DIRECTED[r].exp_cls);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            nc_val = $urandom_range(0, 31);
            vl_val = $urandom_range(0, 31);
            narrow = $urandom_range(0, 1);
            sender_idle_en = 1'b1;
            sink_idle_en = 1'b1;
            case (p)
                0: begin nc_val = 16; vl_val = 16; end
                1: begin nc_val = 1; vl_val = 1; end
                2: begin nc_val = 4; vl_val = 3; narrow = 1'b1; end
                3: begin nc_val = 0; vl_val = 0; narrow = 1'b1; end
                4: begin nc_val = 31; vl_val = 31; end
                5:
                begin
                    nc_val = 16;
                    vl_val = 1;
                    sender_idle_en = 1'b0;
                    sink_idle_en = 1'b0;
                end
                6: begin nc_val = 2; vl_val = 16; narrow = 1'b1; end
                NUM_PHASES - 1:
                begin
                    nc_val = 16;
                    vl_val = 16;
                    sender_idle_en = 1'b0;
                    sink_idle_en = 1'b0;
                end
                default: ;
            endcase
            settle();
            write_reg(REG_NUM_CLUSTERS, nc_val);
            write_reg(REG_VECTOR_LENGTH, vl_val);
            // Long result hold-off while items keep coming, so the input backs up.
            if (p == 2)
                hold_req = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if ($urandom_range(0, 99) < (narrow ? 25 : 10))
                    send_item(MODE_LOAD, IDX_W'($urandom), IDX_W'($urandom),
                              pick_value(narrow), 1'b0, '0);
                else
                    send_item(MODE_QUERY, IDX_W'($urandom), IDX_W'($urandom),
                              pick_value(narrow), 1'b0, '0);
            end
        end

        settle();
        if (mismatch_count == 0 && pending_class.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== nearest_centroid_classifier.f =====
rtl/ncc_pkg.sv
rtl/ncc_ram.sv
rtl/ncc_cfg.sv
rtl/ncc_engine.sv
rtl/nearest_centroid_classifier.sv
rtl/ncc_checker.sv
tb/tb.sv
